FILE: design/u8u16_pkg.sv
// shared types and constants for the utf-8 to utf-16be transcoder
// no dependencies

package u8u16_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [20:0] CP_MAX        = 21'h10FFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h010000;
    localparam logic [5:0]  HI_SURR_MARK  = 6'b110110;
    localparam logic [5:0]  LO_SURR_MARK  = 6'b110111;

    // one queued job for the output side
    typedef struct packed {
        logic        err;
        logic [20:0] cp;
    } cmd_t;

endpackage

FILE: design/u8u16_front.sv
// input side: takes utf-8 bytes, gathers code points, queues output jobs
// depends on u8u16_pkg

module u8u16_front
    import u8u16_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_accept,
    input  logic [7:0] in_byte,
    output logic       push,
    output cmd_t       push_cmd
);

    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] LEAD_MIN  = 8'hC0;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MAX = 8'hF7;

    logic [1:0]  pending_reg, pending_next;
    logic [20:0] acc_reg, acc_next;
    logic        halted_reg, halted_next;
    logic [20:0] shifted;

    assign shifted = {acc_reg[14:0], in_byte[5:0]};

    always_comb
    begin
        pending_next = pending_reg;
        acc_next     = acc_reg;
        halted_next  = halted_reg;
        push         = 1'b0;
        push_cmd.err = 1'b0;
        push_cmd.cp  = {13'd0, in_byte};
        if (in_accept && !halted_reg)
        begin
            if (pending_reg != 2'd0)
            begin
                acc_next     = shifted;
                pending_next = pending_reg - 2'd1;
                push_cmd.cp  = shifted;
                if (pending_reg == 2'd1 && shifted <= CP_MAX)
                begin
                    push = 1'b1;
                end
            end
            else if (in_byte <= ASCII_MAX)
            begin
                push = 1'b1;
            end
            else if (in_byte < LEAD_MIN)
            begin
                // stray continuation byte
                halted_next  = 1'b1;
                push         = 1'b1;
                push_cmd.err = 1'b1;
            end
            else if (in_byte <= LEAD2_MAX)
            begin
                acc_next     = {16'd0, in_byte[4:0]};
                pending_next = 2'd1;
            end
            else if (in_byte <= LEAD3_MAX)
            begin
                acc_next     = {17'd0, in_byte[3:0]};
                pending_next = 2'd2;
            end
            else if (in_byte <= LEAD4_MAX)
            begin
                acc_next     = {18'd0, in_byte[2:0]};
                pending_next = 2'd3;
            end
            else
            begin
                push = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            acc_reg     <= 21'd0;
            halted_reg  <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            acc_reg     <= acc_next;
            halted_reg  <= halted_next;
        end
    end

endmodule

FILE: design/u8u16_queue.sv
// short job queue between the input and output sides
// depends on u8u16_pkg

module u8u16_queue
    import u8u16_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    cmd_t          slots_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == FULL_CNT);
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/u8u16_back.sv
// output side: turns queued code points into utf-16be bytes, one per cycle while m_tready allows
// depends on u8u16_pkg

module u8u16_back
    import u8u16_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       empty,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

    logic [1:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [7:0]  data_reg, data_next;
    logic        last_reg, last_next;
    logic        err_reg, err_next;
    logic        load;
    logic [19:0] offset;
    logic [15:0] hi_word, lo_word;
    logic [7:0]  sel_byte;
    logic        sel_last;

    assign offset  = 20'(head.cp - SUPP_BASE);
    assign hi_word = {HI_SURR_MARK, offset[19:10]};
    assign lo_word = {LO_SURR_MARK, offset[9:0]};
    assign load    = !valid_reg || m_tready;

    always_comb
    begin
        sel_byte = 8'd0;
        sel_last = 1'b0;
        if (head.err)
        begin
            sel_last = 1'b1;
        end
        else if (head.cp[20:16] == 5'd0)
        begin
            sel_byte = idx_reg[0] ? head.cp[7:0] : head.cp[15:8];
            sel_last = idx_reg[0];
        end
        else
        begin
            case (idx_reg)
                2'd0:    sel_byte = hi_word[15:8];
                2'd1:    sel_byte = hi_word[7:0];
                2'd2:    sel_byte = lo_word[15:8];
                default:
                begin
                    sel_byte = lo_word[7:0];
                    sel_last = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                data_next = sel_byte;
                last_next = sel_last;
                err_next  = head.err;
                if (sel_last)
                begin
                    pop      = 1'b1;
                    idx_next = 2'd0;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = err_reg;

endmodule

FILE: design/utf8_to_utf16be_transcoder.sv
// utf-8 to utf-16 big-endian transcoder, top level
// depends on u8u16_pkg, u8u16_front, u8u16_queue, u8u16_back
//
// input stream s_*: one utf-8 byte per item in s_tdata
// output stream m_*: one utf-16be byte per item in m_tdata, m_tlast on the
// final byte caused by an input byte, m_tuser set on the error item
// an ascii or pass-through byte gives two output items, a multi-byte
// sequence gives two or four items on its final byte (none above 10ffff),
// nothing before
// a stray continuation byte as lead gives one error item (data zero); the
// block then swallows every further input item until reset
// input items are taken while the job queue has room; the output side
// sends one byte per cycle while the receiver is ready
// with an idle output side, the job for the final input byte enters the
// queue as that byte is taken and then passes through the output register
// reset clears decoder state, queue pointers and count, and output valid
// a stalled receiver holds the output item; jobs back up in the queue and
// s_tready falls once it is full

module utf8_to_utf16be_transcoder
    import u8u16_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte[7:0]
    output logic       m_tlast,
    output logic       m_tuser    // error
);

    logic push, pop, empty, full;
    cmd_t push_cmd, head;

    assign s_tready = !full;

    u8u16_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (s_tvalid && s_tready),
        .in_byte   (s_tdata),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    u8u16_queue #(.DEPTH(DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    u8u16_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// testbench for utf8_to_utf16be_transcoder: drives utf-8 bytes, predicts the utf-16be bytes
// and checks every output item in order; depends on design/utf8_to_utf16be_transcoder.sv

module tb;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } utf16_byte_t;

    class utf16be_scoreboard;
        utf16_byte_t utf16_due[$];
        logic [1:0]  cont_left;
        logic [20:0] cp_acc;
        logic        stopped;
        int          mismatches;

        function new();
            cont_left  = 2'd0;
            cp_acc     = 21'd0;
            stopped    = 1'b0;
            mismatches = 0;
        endfunction

        function void push_byte(logic [7:0] d, logic l, logic e);
            utf16_due.push_back({d, l, e});
        endfunction

        function void push_code(logic [20:0] cp);
            logic [19:0] v;
            logic [15:0] hi;
            logic [15:0] lo;
            if (cp <= 21'h00FFFF)
            begin
                push_byte(cp[15:8], 1'b0, 1'b0);
                push_byte(cp[7:0], 1'b1, 1'b0);
            end
            else if (cp <= 21'h10FFFF)
            begin
                v  = 20'(cp - 21'h010000);
                hi = 16'hD800 + {6'd0, v[19:10]};
                lo = 16'hDC00 + {6'd0, v[9:0]};
                push_byte(hi[15:8], 1'b0, 1'b0);
                push_byte(hi[7:0], 1'b0, 1'b0);
                push_byte(lo[15:8], 1'b0, 1'b0);
                push_byte(lo[7:0], 1'b1, 1'b0);
            end
        endfunction

        function void note_utf8_byte(logic [7:0] b);
            if (stopped)
                return;
            if (cont_left != 2'd0)
            begin
                // any byte counts as a continuation here
                cp_acc    = {cp_acc[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                    push_code(cp_acc);
                return;
            end
            if (b <= 8'h7F)
                push_code({13'd0, b});
            else if (b < 8'hC0)
            begin
                stopped = 1'b1;
                push_byte(8'h00, 1'b1, 1'b1);
            end
            else if (b <= 8'hDF)
            begin
                cp_acc    = {16'd0, b[4:0]};
                cont_left = 2'd1;
            end
            else if (b <= 8'hEF)
            begin
                cp_acc    = {17'd0, b[3:0]};
                cont_left = 2'd2;
            end
            else if (b <= 8'hF7)
            begin
                cp_acc    = {18'd0, b[2:0]};
                cont_left = 2'd3;
            end
            else
                push_code({13'd0, b});
        endfunction

        function void check_utf16_byte(logic [7:0] d, logic l, logic e);
            utf16_byte_t want;
            if (utf16_due.size() == 0)
            begin
                $display("%0t: unexpected item, actual data %h last %b error %b",
                         $time, d, l, e);
                mismatches++;
                return;
            end
            want = utf16_due.pop_front();
            if (d !== want.data)
            begin
                $display("%0t: data expected %h actual %h", $time, want.data, d);
                mismatches++;
            end
            if (l !== want.last)
            begin
                $display("%0t: last expected %b actual %b", $time, want.last, l);
                mismatches++;
            end
            if (e !== want.err)
            begin
                $display("%0t: error expected %b actual %b", $time, want.err, e);
                mismatches++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    utf16be_scoreboard sb = new();
    logic calm_tx = 1'b0;
    logic calm_rx = 1'b0;
    int   bytes_sent = 0;

    utf8_to_utf16be_transcoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // in_byte[7:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // out_byte[7:0]
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)    // error
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = calm_tx ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_utf8_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.utf16_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    task automatic send_random_char();
        int         kind;
        int         n_cont;
        logic [7:0] lead;
        kind   = $urandom_range(0, 99);
        n_cont = 0;
        if (kind < 30)
            lead = 8'($urandom_range(8'h00, 8'h7F));
        else if (kind < 48)
        begin
            lead   = 8'($urandom_range(8'hC0, 8'hDF));
            n_cont = 1;
        end
        else if (kind < 66)
        begin
            lead   = 8'($urandom_range(8'hE0, 8'hEF));
            n_cont = 2;
        end
        else if (kind < 88)
        begin
            // mostly in range, now and then above the last code point
            lead   = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(8'hF4, 8'hF7))
                                                 : 8'($urandom_range(8'hF0, 8'hF4));
            n_cont = 3;
        end
        else if (kind < 94)
            lead = 8'($urandom_range(8'hF8, 8'hFF));
        else
        begin
            // broken sequence: continuation slots filled with arbitrary bytes
            lead = 8'($urandom_range(8'hC0, 8'hF7));
            send_byte(lead);
            repeat ((lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1)
                send_byte(8'($urandom_range(0, 255)));
            return;
        end
        send_byte(lead);
        if (n_cont == 3 && lead == 8'hF4 && $urandom_range(0, 3) != 0)
        begin
            send_byte(8'($urandom_range(8'h80, 8'h8F)));
            n_cont = 2;
        end
        repeat (n_cont)
            send_byte(cont_byte());
    endtask

    // directed opening: extremes, each sequence length, surrogate pair limits,
    // code point above range, pass-through bytes, non-continuation in a sequence
    logic [7:0] opening_bytes [] = '{
        8'h00, 8'h7F,
        8'hC2, 8'hA9,
        8'hE0, 8'h80, 8'h80,
        8'hEF, 8'hBF, 8'hBF,
        8'hF0, 8'h90, 8'h80, 8'h80,
        8'hF4, 8'h8F, 8'hBF, 8'hBF,
        8'hF7, 8'hBF, 8'hBF, 8'hBF,
        8'hF8, 8'hFF,
        8'hC3, 8'hFF
    };

    initial
    begin
        int n;
        wait (rst_n === 1'b1);
        @(posedge clk);
        n = 0;
        forever
        begin
            if (n % 24 == 0)
                calm_rx = ($urandom_range(0, 2) == 0);
            if (!calm_rx && $urandom_range(0, 1) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_utf16_byte(m_tdata, m_tlast, m_tuser);
            n++;
        end
    end

    initial
    begin
        logic paused;
        int   chars;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_bytes[i])
            send_byte(opening_bytes[i]);
        wait_drained();

        paused = 1'b0;
        chars  = 0;
        while (bytes_sent < 326)
        begin
            if (chars % 20 == 0)
                calm_tx = ($urandom_range(0, 2) == 0);
            send_random_char();
            chars++;
            if ((!paused && bytes_sent >= 170) || $urandom_range(0, 59) == 0)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end

        // stray continuation as lead, then the block ignores everything
        calm_tx = 1'b0;
        send_byte(8'($urandom_range(8'h80, 8'hBF)));
        repeat (6)
            send_byte(8'($urandom_range(0, 255)));
        wait_drained();
        repeat (20) @(posedge clk);

        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
